### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wssg_pkg.sv
// ----------------------------------------------------------------------------
// wssg_pkg
// Types, constants and helper functions of the wire sphere segment generator.
// ----------------------------------------------------------------------------
package wssg_pkg;

  localparam int MAX_SUBDIV_DEF = 16;
  localparam int COORD_W        = 32;
  localparam int RAD_W          = 31;
  localparam int N_W            = 5;
  localparam int CLR_W          = 32;
  localparam int IN_W           = 168;
  localparam int OUT_W          = 224;
  localparam int V_W            = 34;
  localparam int PT_W           = 2 * V_W;
  localparam int CORDIC_STEPS   = 30;

  localparam logic [30:0]           HALF_PI_Q30 = 31'h6487ED51;
  localparam logic signed [V_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVI,
    ST_DIV,
    ST_ANG,
    ST_ROT,
    ST_MULC,
    ST_MULS,
    ST_WR,
    ST_LD0,
    ST_LD0W,
    ST_SEGRD,
    ST_SEGW,
    ST_SEGOUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       ang_load;
    logic       rot_step;
    logic       mul_c;
    logic       mul_s;
    logic       ram_we;
    logic       ld_p0;
    logic       seg_load;
    logic       wrap;
    logic       adv;
    logic       new_circ;
    logic [4:0] rot_k;
    logic [1:0] circ;
  } dp_cmd_t;

  typedef struct packed {
    logic [N_W-1:0] n_eff;
    logic           in_n_zero;
  } dp_sts_t;

  function automatic logic [31:0] atan_q30(logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] cen, logic [V_W-1:0] off);
    logic signed [34:0] s;
    s = 35'($signed(cen)) + 35'($signed(off));
    if (s > 35'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (s < -35'sd2147483648) begin
      return 32'h80000000;
    end
    return s[31:0];
  endfunction

endpackage

### sv/wire_sphere_segment_generator_top.sv
// ----------------------------------------------------------------------------
// wire_sphere_segment_generator_top
// Emits the 3*N segments of three great circles of a wireframe sphere.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_     | slave     | tdata: center_x, center_y, center_z, radius, subdivisions, color
// out_    | master    | tdata: start_x..end_z, line_color; tlast: last_segment
//
// Each point is made by a phase divider of 32 + CW bit steps, a 30-step
// CORDIC loop and two passes through one radius multiplier.
// A request is accepted, its N points are computed and stored, the first point
// is fetched and the segments are emitted, each held while back-pressure lasts.
// A request with zero subdivisions is taken and produces nothing.
// Reset returns the sequencer to idle; a stalled segment holds its register.
module wire_sphere_segment_generator_top #(
  parameter int MAX_SUBDIV = wssg_pkg::MAX_SUBDIV_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // center_x, center_y, center_z, radius, subdivisions, color, zero pad
  input  logic [wssg_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, line_color
  output logic [wssg_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int CW = $clog2(MAX_SUBDIV + 1);
  localparam int AW = (MAX_SUBDIV > 1) ? $clog2(MAX_SUBDIV) : 1;

  wssg_pkg::dp_cmd_t cmd;
  wssg_pkg::dp_sts_t sts;
  logic [CW-1:0] idx;
  logic [AW-1:0] raddr;

  wssg_ctrl #(.MAX_SUBDIV(MAX_SUBDIV), .CW(CW), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .idx        (idx),
    .raddr      (raddr)
  );

  wssg_datapath #(.MAX_SUBDIV(MAX_SUBDIV), .CW(CW), .AW(AW)) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .idx      (idx),
    .raddr    (raddr),
    .in_data  (in_tdata),
    .sts      (sts),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

endmodule

### sv/wssg_ram.sv
// ----------------------------------------------------------------------------
// wssg_ram
// Generic simple dual-port RAM with a registered read.
// ----------------------------------------------------------------------------
module wssg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/wssg_datapath.sv
// ----------------------------------------------------------------------------
// wssg_datapath
// Phase divider, CORDIC, radius scaling, point store and segment assembly.
// ----------------------------------------------------------------------------
module wssg_datapath #(
  parameter int MAX_SUBDIV = wssg_pkg::MAX_SUBDIV_DEF,
  parameter int CW         = $clog2(MAX_SUBDIV + 1),
  parameter int AW         = (MAX_SUBDIV > 1) ? $clog2(MAX_SUBDIV) : 1
) (
  input  logic                        clk,
  input  wssg_pkg::dp_cmd_t           cmd,
  input  logic [CW-1:0]               idx,
  input  logic [AW-1:0]               raddr,
  input  logic [wssg_pkg::IN_W-1:0]   in_data,
  output wssg_pkg::dp_sts_t           sts,
  output logic [wssg_pkg::OUT_W-1:0]  out_data,
  output logic                        out_last
);

  localparam int NUMW = CW + 32;
  localparam int VW   = wssg_pkg::V_W;
  localparam int PW   = wssg_pkg::PT_W;

  logic [31:0] cx_r, cy_r, cz_r, clr_r;
  logic [30:0] rad_r;
  logic [4:0]  n_r;
  logic [4:0]  in_n;
  logic [NUMW-1:0] num_r;
  logic [4:0]  rem_r;
  logic [31:0] quo_r;
  logic [5:0]  dv_t;
  logic        dv_ge;
  logic [1:0]  q_r;
  logic [60:0] ang_prod;
  logic signed [VW-1:0] x_r, y_r, z_r, dx, dy, at;
  logic signed [VW-1:0] c_v, s_v, mop;
  logic signed [65:0] sprod;
  logic signed [65:0] srnd;
  logic [VW-1:0] offc_r, offs_r;
  logic [PW-1:0] rdata, p0_r, cur_r, next_r, nxt_pt;
  logic [VW-1:0] so [3];
  logic [VW-1:0] eo [3];
  logic [wssg_pkg::OUT_W-1:0] out_r;
  logic last_r;

  assign in_n          = in_data[131:127];
  assign sts.in_n_zero = (in_n == 5'd0);
  assign sts.n_eff     = n_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r  <= in_data[31:0];
      cy_r  <= in_data[63:32];
      cz_r  <= in_data[95:64];
      rad_r <= in_data[126:96];
      n_r   <= (in_n > 5'(MAX_SUBDIV)) ? 5'(MAX_SUBDIV) : in_n;
      clr_r <= in_data[163:132];
    end
  end

  assign dv_t  = {rem_r, num_r[NUMW-1]};
  assign dv_ge = (dv_t >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= {idx, 32'd0};
      rem_r <= 5'd0;
      quo_r <= 32'd0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUMW-2:0], 1'b0};
      rem_r <= dv_ge ? 5'(dv_t - {1'b0, n_r}) : dv_t[4:0];
      quo_r <= {quo_r[30:0], dv_ge};
    end
  end

  assign ang_prod = 61'(quo_r[29:0]) * 61'(wssg_pkg::HALF_PI_Q30);
  assign dx = y_r >>> cmd.rot_k;
  assign dy = x_r >>> cmd.rot_k;
  assign at = VW'($signed({1'b0, wssg_pkg::atan_q30(cmd.rot_k)}));

  always_ff @(posedge clk) begin
    if (cmd.ang_load) begin
      q_r <= quo_r[31:30];
      z_r <= $signed(VW'(ang_prod[60:30]));
      x_r <= wssg_pkg::CORDIC_GAIN;
      y_r <= '0;
    end else if (cmd.rot_step) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  always_comb begin
    case (q_r)
      2'd0: begin c_v = x_r;  s_v = y_r;  end
      2'd1: begin c_v = -y_r; s_v = x_r;  end
      2'd2: begin c_v = -x_r; s_v = -y_r; end
      default: begin c_v = y_r; s_v = -x_r; end
    endcase
  end

  assign mop   = cmd.mul_s ? s_v : c_v;
  assign sprod = 66'($signed({1'b0, rad_r})) * 66'(mop);
  assign srnd  = sprod + 66'sd536870912;

  always_ff @(posedge clk) begin
    if (cmd.mul_c) begin
      offc_r <= srnd[63:30];
    end
    if (cmd.mul_s) begin
      offs_r <= srnd[63:30];
    end
  end

  wssg_ram #(.WIDTH(PW), .DEPTH(MAX_SUBDIV), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (AW'(idx)),
    .wdata ({offs_r, offc_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign nxt_pt = cmd.wrap ? p0_r : rdata;

  always_comb begin
    case (cmd.circ)
      2'd0: begin
        so[0] = cur_r[VW-1:0];    so[1] = cur_r[PW-1:VW];   so[2] = '0;
        eo[0] = nxt_pt[VW-1:0];   eo[1] = nxt_pt[PW-1:VW];  eo[2] = '0;
      end
      2'd1: begin
        so[0] = cur_r[VW-1:0];    so[1] = '0;               so[2] = cur_r[PW-1:VW];
        eo[0] = nxt_pt[VW-1:0];   eo[1] = '0;               eo[2] = nxt_pt[PW-1:VW];
      end
      default: begin
        so[0] = '0;               so[1] = cur_r[VW-1:0];    so[2] = cur_r[PW-1:VW];
        eo[0] = '0;               eo[1] = nxt_pt[VW-1:0];   eo[2] = nxt_pt[PW-1:VW];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_p0) begin
      p0_r  <= rdata;
      cur_r <= rdata;
    end else if (cmd.adv) begin
      cur_r <= cmd.new_circ ? p0_r : next_r;
    end
    if (cmd.seg_load) begin
      next_r <= nxt_pt;
      last_r <= cmd.wrap && (cmd.circ == 2'd2);
      out_r  <= {clr_r,
                 wssg_pkg::sat_add(cz_r, eo[2]),
                 wssg_pkg::sat_add(cy_r, eo[1]),
                 wssg_pkg::sat_add(cx_r, eo[0]),
                 wssg_pkg::sat_add(cz_r, so[2]),
                 wssg_pkg::sat_add(cy_r, so[1]),
                 wssg_pkg::sat_add(cx_r, so[0])};
    end
  end

  assign out_data = out_r;
  assign out_last = last_r;

endmodule

### sv/wssg_ctrl.sv
// ----------------------------------------------------------------------------
// wssg_ctrl
// Sequencer for point generation and segment emission.
// ----------------------------------------------------------------------------
module wssg_ctrl #(
  parameter int MAX_SUBDIV = wssg_pkg::MAX_SUBDIV_DEF,
  parameter int CW         = $clog2(MAX_SUBDIV + 1),
  parameter int AW         = (MAX_SUBDIV > 1) ? $clog2(MAX_SUBDIV) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  wssg_pkg::dp_sts_t sts,
  output wssg_pkg::dp_cmd_t cmd,
  output logic [CW-1:0]     idx,
  output logic [AW-1:0]     raddr
);

  localparam int NUMW = CW + 32;
  localparam int CNTW = $clog2(NUMW);

  wssg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [1:0]      circ_r, circ_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            wrap;
  logic            div_end, rot_end;

  assign wrap    = (5'(idx_r) + 5'd1) == sts.n_eff;
  assign div_end = cnt_r == CNTW'(NUMW - 1);
  assign rot_end = cnt_r == CNTW'(wssg_pkg::CORDIC_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wssg_pkg::ST_IDLE;
      idx_r   <= '0;
      circ_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      circ_r  <= circ_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wssg_pkg::ST_IDLE:
        if (in_tvalid && !sts.in_n_zero) state_nxt = wssg_pkg::ST_DIVI;
      wssg_pkg::ST_DIVI: state_nxt = wssg_pkg::ST_DIV;
      wssg_pkg::ST_DIV:  if (div_end) state_nxt = wssg_pkg::ST_ANG;
      wssg_pkg::ST_ANG:  state_nxt = wssg_pkg::ST_ROT;
      wssg_pkg::ST_ROT:  if (rot_end) state_nxt = wssg_pkg::ST_MULC;
      wssg_pkg::ST_MULC: state_nxt = wssg_pkg::ST_MULS;
      wssg_pkg::ST_MULS: state_nxt = wssg_pkg::ST_WR;
      wssg_pkg::ST_WR:   state_nxt = wrap ? wssg_pkg::ST_LD0 : wssg_pkg::ST_DIVI;
      wssg_pkg::ST_LD0:  state_nxt = wssg_pkg::ST_LD0W;
      wssg_pkg::ST_LD0W: state_nxt = wssg_pkg::ST_SEGRD;
      wssg_pkg::ST_SEGRD: state_nxt = wssg_pkg::ST_SEGW;
      wssg_pkg::ST_SEGW:  state_nxt = wssg_pkg::ST_SEGOUT;
      wssg_pkg::ST_SEGOUT:
        if (out_tready) begin
          state_nxt = (wrap && circ_r == 2'd2) ? wssg_pkg::ST_IDLE : wssg_pkg::ST_SEGRD;
        end
      default: state_nxt = wssg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    circ_nxt = circ_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      wssg_pkg::ST_IDLE: idx_nxt = '0;
      wssg_pkg::ST_DIVI: cnt_nxt = '0;
      wssg_pkg::ST_DIV:  cnt_nxt = div_end ? '0 : cnt_r + 1'b1;
      wssg_pkg::ST_ANG:  cnt_nxt = '0;
      wssg_pkg::ST_ROT:  cnt_nxt = cnt_r + 1'b1;
      wssg_pkg::ST_WR:   if (!wrap) idx_nxt = idx_r + 1'b1;
      wssg_pkg::ST_LD0W: begin
        idx_nxt  = '0;
        circ_nxt = '0;
      end
      wssg_pkg::ST_SEGOUT:
        if (out_tready) begin
          if (wrap) begin
            idx_nxt  = '0;
            circ_nxt = circ_r + 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      default: ;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rot_k  = cnt_r[4:0];
    cmd.circ   = circ_r;
    cmd.wrap   = wrap;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    raddr      = '0;
    unique case (state_r)
      wssg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      wssg_pkg::ST_DIVI:  cmd.div_init = 1'b1;
      wssg_pkg::ST_DIV:   cmd.div_step = 1'b1;
      wssg_pkg::ST_ANG:   cmd.ang_load = 1'b1;
      wssg_pkg::ST_ROT:   cmd.rot_step = 1'b1;
      wssg_pkg::ST_MULC:  cmd.mul_c = 1'b1;
      wssg_pkg::ST_MULS:  cmd.mul_s = 1'b1;
      wssg_pkg::ST_WR:    cmd.ram_we = 1'b1;
      wssg_pkg::ST_LD0:   raddr = '0;
      wssg_pkg::ST_LD0W:  cmd.ld_p0 = 1'b1;
      wssg_pkg::ST_SEGRD: raddr = AW'(idx_r + 1'b1);
      wssg_pkg::ST_SEGW:  cmd.seg_load = 1'b1;
      wssg_pkg::ST_SEGOUT: begin
        out_tvalid   = 1'b1;
        cmd.adv      = out_tready;
        cmd.new_circ = wrap;
      end
      default: ;
    endcase
  end

  assign idx = idx_r;

endmodule

### sv/wssg_checker.sv
// ----------------------------------------------------------------------------
// wssg_checker
// Port-level checks of the segment generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wssg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [167:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "Segment dropped while stalled.")
  `CHK_SAME(a_one_side, clk, rst_n, in_tready, !out_tvalid, "Request taken while segments are pending.")
  `CHK_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready && in_tdata[131:127] != 5'd0, !in_tready, "Request did not start work.")
  `CHK_NEXT(a_done, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready && !out_tvalid, "Block not idle after final segment.")

endmodule

bind wire_sphere_segment_generator_top wssg_checker u_wssg_checker (.*);
